// ----- hdl/mjsg_pkg.sv -----
// Package for the multi-jittered sample generator.
// Holds shared widths, the sequencer and phase encodings; no dependencies.
`timescale 1ns / 1ps

package mjsg_pkg;

    localparam int MAX_SIDE      = 8;
    localparam int SIDE_W        = 4;
    localparam int POS_W         = 3;
    localparam int CELL_W        = 6;
    localparam int ADDR_W        = 6;
    localparam int TABLE_DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int WORD_W        = 31;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_FRAC_W    = 16;
    localparam int OUT_DATA_W    = 56;
    localparam int FRAC_BITS_DEF = 16;
    localparam int REM_W         = 3;
    localparam int MOD_DIGIT_W   = 8;
    localparam int MOD_CNT_W     = 2;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_MOD       = 7'b0000010,
        ST_READ      = 7'b0000100,
        ST_WR_A      = 7'b0001000,
        ST_WR_B      = 7'b0010000,
        ST_EMIT_RD   = 7'b0100000,
        ST_EMIT_WAIT = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_JITTER = 3'b001,
        PH_XSHUF  = 3'b010,
        PH_YSHUF  = 3'b100
    } phase_t;

endpackage

// ----- hdl/multi_jittered_sample_generator_top.sv -----
// Multi-jittered sample generator: one top level with its two sample tables.
// Depends on mjsg_pkg.
`timescale 1ns / 1ps
//
// Usage:
// Random words arrive as transfers on the s_axis channel, one 31-bit word each.
// For a side n, the first 2*n*n words set the x and y jitter of every cell.
// The next 2*n*(n-1) words drive the row shuffle of x and then the column
// shuffle of y. The transfer that completes the pattern starts emission.
// During emission n*n samples leave on m_axis in index order, tlast on the final one.
// A jitter word is written to its table in its own transfer cycle. A shuffle word
// goes from the transfer to the shared remainder unit in ST_MOD (eight bits per
// cycle), then to one table read in ST_READ and two writes in ST_WR_A and ST_WR_B
// through the single write port of the table. Each sample has its table read in
// ST_EMIT_RD and its output transfer in ST_EMIT_WAIT, held while the receiver stalls
// with tready low; the sample then stays in its register and s_axis_tready is low.
// After reset the side is 8 and a new pattern begins with its jitter phase.
// The tables need no clearing, since every entry is written before it is read.
// cfg_we sets the side and restarts the pattern; the user asserts it only while idle.

module multi_jittered_sample_generator_top
    import mjsg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [SIDE_W-1:0]     cfg_wdata,      // grid_side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // random_word[30:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sample_index[5:0], x_cell[11:6], x_frac[27:12], y_cell[33:28], y_frac[49:34]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int ENTRY_W = CELL_W + FRAC_BITS;

    logic [ENTRY_W-1:0] x_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] y_mem [TABLE_DEPTH];

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [SIDE_W-1:0]      side_reg;
    logic [POS_W-1:0]       row_reg, row_next;
    logic [POS_W-1:0]       col_reg, col_next;
    logic                   axis_reg, axis_next;
    logic [IN_DATA_W-1:0]   word_reg, word_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [MOD_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;

    logic [ENTRY_W-1:0]     x_rd_a_reg, x_rd_b_reg, y_rd_a_reg, y_rd_b_reg;

    logic [SIDE_W-1:0]      side_eff;
    logic [SIDE_W-1:0]      col_p1, row_p1, mod_div;
    logic [POS_W-1:0]       k_pos;
    logic [ADDR_W-1:0]      n_w, row_w, col_w, k_w;
    logic [ADDR_W-1:0]      row_base, col_base, k_base;
    logic [ADDR_W-1:0]      rc_addr, cr_addr, addr_a, addr_b, last_idx;
    logic [FRAC_BITS-1:0]   frac_in;
    logic                   in_xfer, out_xfer, rd_en;
    logic                   x_we, y_we;
    logic [ADDR_W-1:0]      x_waddr, y_waddr;
    logic [ENTRY_W-1:0]     x_wdata, y_wdata;
    logic [FRAC_BITS+OUT_FRAC_W-1:0] x_frac_ext, y_frac_ext;

    function automatic logic [REM_W-1:0] mod_digits(
        input logic [REM_W-1:0]       r_in,
        input logic [MOD_DIGIT_W-1:0] bits,
        input logic [SIDE_W-1:0]      m
    );
        logic [SIDE_W-1:0] t;
        logic [REM_W-1:0]  r;
        r = r_in;
        for (int i = MOD_DIGIT_W - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= m)
            begin
                t = t - m;
            end
            r = t[REM_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        if (side_reg == '0)
        begin
            side_eff = SIDE_W'(1);
        end
        else if (side_reg > SIDE_W'(MAX_SIDE))
        begin
            side_eff = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = side_reg;
        end
    end

    assign k_pos    = col_reg + rem_reg;
    assign n_w      = ADDR_W'(side_eff);
    assign row_w    = ADDR_W'(row_reg);
    assign col_w    = ADDR_W'(col_reg);
    assign k_w      = ADDR_W'(k_pos);
    assign row_base = row_w * n_w;
    assign col_base = col_w * n_w;
    assign k_base   = k_w * n_w;
    assign rc_addr  = row_base + col_w;
    assign cr_addr  = col_base + row_w;
    assign last_idx = n_w * n_w - ADDR_W'(1);
    assign col_p1   = SIDE_W'(col_reg) + SIDE_W'(1);
    assign row_p1   = SIDE_W'(row_reg) + SIDE_W'(1);
    assign mod_div  = side_eff - SIDE_W'(col_reg);
    assign frac_in  = s_axis_tdata[WORD_W-1 -: FRAC_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT_WAIT);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign rd_en         = (state_reg == ST_READ) || (state_reg == ST_EMIT_RD);

    always_comb
    begin
        if (state_reg == ST_EMIT_RD)
        begin
            addr_a = idx_reg;
        end
        else if (phase_reg == PH_XSHUF)
        begin
            addr_a = rc_addr;
        end
        else
        begin
            addr_a = cr_addr;
        end
        addr_b = (phase_reg == PH_XSHUF) ? (row_base + k_w) : (k_base + row_w);
    end

    always_comb
    begin
        x_we    = 1'b0;
        y_we    = 1'b0;
        x_waddr = rc_addr;
        y_waddr = rc_addr;
        x_wdata = {rc_addr, frac_in};
        y_wdata = {cr_addr, frac_in};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && phase_reg == PH_JITTER)
                begin
                    x_we = !axis_reg;
                    y_we = axis_reg;
                end
            end
            ST_WR_A:
            begin
                x_we    = (phase_reg == PH_XSHUF);
                y_we    = (phase_reg == PH_YSHUF);
                x_waddr = addr_a;
                y_waddr = addr_a;
                x_wdata = x_rd_b_reg;
                y_wdata = y_rd_b_reg;
            end
            ST_WR_B:
            begin
                x_we    = (phase_reg == PH_XSHUF);
                y_we    = (phase_reg == PH_YSHUF);
                x_waddr = addr_b;
                y_waddr = addr_b;
                x_wdata = x_rd_a_reg;
                y_wdata = y_rd_a_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        axis_next  = axis_reg;
        word_next  = word_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (phase_reg == PH_JITTER)
                    begin
                        axis_next = !axis_reg;
                        if (axis_reg)
                        begin
                            col_next = col_reg + POS_W'(1);
                            if (col_p1 == side_eff)
                            begin
                                col_next = '0;
                                row_next = row_reg + POS_W'(1);
                                if (row_p1 == side_eff)
                                begin
                                    row_next = '0;
                                    if (side_eff == SIDE_W'(1))
                                    begin
                                        idx_next   = '0;
                                        state_next = ST_EMIT_RD;
                                    end
                                    else
                                    begin
                                        phase_next = PH_XSHUF;
                                    end
                                end
                            end
                        end
                    end
                    else
                    begin
                        word_next  = {1'b0, s_axis_tdata[WORD_W-1:0]};
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next  = mod_digits(rem_reg, word_reg[IN_DATA_W-1 -: MOD_DIGIT_W],
                                       mod_div);
                word_next = word_reg << MOD_DIGIT_W;
                cnt_next  = cnt_reg + MOD_CNT_W'(1);
                if (cnt_reg == '1)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WR_A;
            end
            ST_WR_A:
            begin
                state_next = ST_WR_B;
            end
            ST_WR_B:
            begin
                state_next = ST_IDLE;
                col_next   = col_reg + POS_W'(1);
                if (col_p1 == side_eff - SIDE_W'(1))
                begin
                    col_next = '0;
                    row_next = row_reg + POS_W'(1);
                    if (row_p1 == side_eff)
                    begin
                        row_next = '0;
                        if (phase_reg == PH_XSHUF)
                        begin
                            phase_next = PH_YSHUF;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_xfer)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                    if (m_axis_tlast)
                    begin
                        state_next = ST_IDLE;
                        phase_next = PH_JITTER;
                        row_next   = '0;
                        col_next   = '0;
                        axis_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_IDLE;
            phase_next = PH_JITTER;
            row_next   = '0;
            col_next   = '0;
            axis_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_JITTER;
            side_reg  <= SIDE_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                side_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[x_waddr] <= x_wdata;
        end
        if (rd_en)
        begin
            x_rd_a_reg <= x_mem[addr_a];
            x_rd_b_reg <= x_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
        begin
            y_mem[y_waddr] <= y_wdata;
        end
        if (rd_en)
        begin
            y_rd_a_reg <= y_mem[addr_a];
            y_rd_b_reg <= y_mem[addr_b];
        end
    end

    assign x_frac_ext = {{OUT_FRAC_W{1'b0}}, x_rd_a_reg[FRAC_BITS-1:0]};
    assign y_frac_ext = {{OUT_FRAC_W{1'b0}}, y_rd_a_reg[FRAC_BITS-1:0]};

    assign m_axis_tdata = {
        {(OUT_DATA_W - 2 * OUT_FRAC_W - 2 * CELL_W - ADDR_W){1'b0}},
        y_frac_ext[OUT_FRAC_W-1:0],
        y_rd_a_reg[ENTRY_W-1 -: CELL_W],
        x_frac_ext[OUT_FRAC_W-1:0],
        x_rd_a_reg[ENTRY_W-1 -: CELL_W],
        idx_reg
    };
    assign m_axis_tlast = (idx_reg == last_idx);

endmodule

// ----- hdl/mjsg_checker.sv -----
// Port-level checker for the multi-jittered sample generator, bound to the top.
// Depends on mjsg_pkg and multi_jittered_sample_generator_top.
`timescale 1ns / 1ps

module mjsg_checker
    import mjsg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled output transfer changed.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("Input taken while a sample is pending.");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !m_axis_tlast |=> !s_axis_tready)
        else $error("Input ready in the middle of a pattern.");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("Block not ready after the final sample.");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !m_axis_tlast |=> ##1
            m_axis_tvalid && (m_axis_tdata[5:0] == 6'($past(m_axis_tdata[5:0], 2) + 6'd1)))
        else $error("Sample index did not advance by one.");

endmodule

bind multi_jittered_sample_generator_top mjsg_checker u_mjsg_checker (.*);
